// ===== sv/assert_macros.svh =====
// shared assertion macros, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge out of reset
`define CHK_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent at one edge, consequent at the next edge
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rtcm3fs_pkg.sv =====
package rtcm3fs_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned LEN_W   = 10;
  localparam int unsigned TYPE_W  = 12;
  localparam int unsigned HDR_W   = 24;
  localparam int unsigned ODATA_W = 40;

  localparam logic [BYTE_W-1:0] PREAMBLE = 8'hD3;

  // last header byte that is shifted into the header register
  localparam logic [CNT_W-1:0] HDR_LAST_IDX = 11'd4;
  // byte that completes the length field
  localparam logic [CNT_W-1:0] LEN_IDX      = 11'd2;
  // header bytes plus parity bytes around the payload
  localparam logic [CNT_W-1:0] HDR_BYTES    = 11'd3;
  localparam logic [CNT_W-1:0] PAR_BYTES    = 11'd3;

  typedef struct packed {
    logic              in_frame;
    logic [CNT_W-1:0]  byte_index;
    logic              frame_done;
    logic [CNT_W-1:0]  frame_bytes;
    logic [TYPE_W-1:0] message_type;
  } res_t;

endpackage

// ===== sv/rtcm3_frame_sync.sv =====
// rtcm3_frame_sync: byte-wide deframer for rtcm version 3 frames
// in channel: one received byte per beat on in_tdata
// out channel: exactly one beat per input byte
//   out_tuser  = in_frame (byte belongs to a frame)
//   out_tlast  = frame_done (byte is the last parity byte of a frame)
//   out_tdata  = byte_index, frame_bytes, message_type
// bytes outside a frame are reported with every field zero; a preamble
// value seen inside a frame is plain frame data, there is no resync
// the result beat is registered and visible in the cycle after the input beat
// throughput: one byte per cycle while the receiver does not stall; the update is
//   11-bit adds and compares on the byte count plus a preamble match ahead of the output register
// in_tready is high while the output register is empty or being drained,
//   so a stalled receiver stalls the input with no beat lost
// reset (synchronous, rst_n low) empties the output register and returns
//   the block to preamble hunting
// parity is not checked
module rtcm3_frame_sync
  import rtcm3fs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [BYTE_W-1:0]  in_tdata,   // [7:0] rx_byte
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [ODATA_W-1:0] out_tdata,  // [10:0] byte_index, [21:11] frame_bytes,
                                         // [33:22] message_type, [39:34] zero
  output logic               out_tuser,  // [0] in_frame
  output logic               out_tlast   // frame_done
);

  `include "assert_macros.svh"

  // frame state
  logic [CNT_W-1:0] count_r, count_nxt;   // 0 means hunting for preamble
  logic [CNT_W-1:0] plen3_r, plen3_nxt;   // payload length plus 3
  logic [HDR_W-1:0] hdr_r,   hdr_nxt;     // header bytes shifted in

  // output register
  logic             out_valid_r;
  res_t             res_r, res_nxt;

  logic             in_fire;
  logic             idle;
  logic             is_pre;
  logic [CNT_W-1:0] cnt_inc;
  logic             done;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign idle    = (count_r == '0);
  assign is_pre  = (in_tdata == PREAMBLE);
  assign cnt_inc = count_r + 11'd1;

  always_comb begin
    // header shift on bytes 1 to 4
    hdr_nxt = hdr_r;
    if (idle) begin
      if (is_pre) begin
        hdr_nxt = '0;
      end
    end else if (count_r <= HDR_LAST_IDX) begin
      hdr_nxt = {hdr_r[HDR_W-BYTE_W-1:0], in_tdata};
    end

    // length field complete once byte 2 is in
    plen3_nxt = plen3_r;
    if (!idle && count_r == LEN_IDX) begin
      plen3_nxt = CNT_W'(hdr_nxt[LEN_W-1:0]) + HDR_BYTES;
    end

    // frame ends after length plus six bytes
    done = !idle && (count_r >= LEN_IDX) && (cnt_inc >= plen3_nxt + PAR_BYTES);

    if (idle) begin
      count_nxt = is_pre ? 11'd1 : '0;
    end else if (done) begin
      count_nxt = '0;
    end else begin
      count_nxt = cnt_inc;
    end
  end

  always_comb begin
    res_nxt              = '0;
    res_nxt.in_frame     = !idle || is_pre;
    res_nxt.byte_index   = idle ? '0 : count_r;
    res_nxt.frame_done   = done;
    res_nxt.frame_bytes  = done ? cnt_inc : '0;
    res_nxt.message_type = done ? hdr_nxt[TYPE_W+3:4] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      plen3_r     <= '0;
      hdr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r <= count_nxt;
        plen3_r <= plen3_nxt;
        hdr_r   <= hdr_nxt;
      end
      if (in_tready) begin
        out_valid_r <= in_tvalid;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.in_frame;
  assign out_tlast  = res_r.frame_done;
  assign out_tdata  = {{(ODATA_W - 2*CNT_W - TYPE_W){1'b0}},
                       res_r.message_type, res_r.frame_bytes, res_r.byte_index};

  // checks
  `CHK_PROP(a_done_in_frame, (out_tvalid && out_tlast) |-> out_tuser,
            "frame end reported on a byte outside a frame")
  `CHK_PROP(a_len_matches_idx,
            (out_tvalid && out_tlast) |-> (res_r.frame_bytes == res_r.byte_index + 11'd1),
            "frame length disagrees with index of last byte")
  `CHK_PROP(a_drop_zero, (out_tvalid && !out_tuser) |-> (out_tdata == '0 && !out_tlast),
            "dropped byte carries nonzero fields")
  `CHK_NEXT(a_done_to_idle, (in_fire && done), (count_r == '0),
            "block did not return to hunting after frame end")

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  import rtcm3fs_pkg::*;

  localparam int WDOG_LIMIT = 1000;  // cycles without any beat before giving up
  localparam int HOLD_CYCLES = 80;   // long receiver hold-off
  localparam int TAIL_CYCLES = 5;    // settle time after the last result

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [BYTE_W-1:0]  in_tdata = '0;     // [7:0] rx_byte
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [ODATA_W-1:0] out_tdata;         // [10:0] byte_index, [21:11] frame_bytes,
                                         // [33:22] message_type, [39:34] zero
  logic               out_tuser;         // [0] in_frame
  logic               out_tlast;         // frame_done

  rtcm3_frame_sync dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // bytes waiting to be sent and per-byte results still owed by the block
  logic [BYTE_W-1:0] tx_bytes[$];
  res_t              owed_results[$];

  // deframer state mirrored on the bench side
  logic [CNT_W-1:0]  frm_pos = '0;    // 0 means hunting for the preamble
  logic [CNT_W-1:0]  len_p3 = '0;     // payload length plus header bytes
  logic [23:0]       hdr_shift = '0;  // bytes 1..4 shifted in

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int bytes_planned = 0;
  int bytes_accepted = 0;
  int results_checked = 0;
  int frames_closed = 0;
  int errors = 0;
  int hold_req = 0;                    // bumped to ask the receiver for a long hold-off
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  logic in_taken = 1'b0;               // input beat accepted at the last rising edge

  // expected result of one received byte, advances the mirrored state
  function automatic res_t deframe_byte(input logic [BYTE_W-1:0] b);
    res_t r;
    logic [CNT_W-1:0] idx;
    r = '0;
    if (frm_pos == '0) begin
      // hunting: only the preamble opens a frame, everything else is dropped
      if (b == PREAMBLE) begin
        frm_pos = 11'd1;
        hdr_shift = '0;
        r.in_frame = 1'b1;
      end
      return r;
    end
    idx = frm_pos;
    if (idx <= 11'd4) hdr_shift = {hdr_shift[15:0], b};
    // length field complete once byte 2 is in
    if (idx == 11'd2) len_p3 = {1'b0, hdr_shift[9:0]} + 11'd3;
    frm_pos = idx + 11'd1;
    r.in_frame = 1'b1;
    r.byte_index = idx;
    // last parity byte closes the frame; a preamble value inside is just data
    if (idx >= 11'd2 && frm_pos >= len_p3 + 11'd3) begin
      r.frame_done = 1'b1;
      r.frame_bytes = frm_pos;
      r.message_type = hdr_shift[15:4];
      frm_pos = '0;
    end
    return r;
  endfunction

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    tx_bytes.push_back(b);
    bytes_planned++;
  endtask

  // one well-formed frame: preamble, length, type in bytes 3/4, random rest
  task automatic add_frame(input logic [9:0] len, input logic [11:0] mtype,
                           input int d3_pct);
    int n;
    logic [BYTE_W-1:0] b;
    n = int'(len) + 6;
    for (int i = 0; i < n; i++) begin
      case (i)
        0: b = PREAMBLE;
        1: b = {6'($urandom_range(63)), len[9:8]};  // reserved bits random
        2: b = len[7:0];
        3: b = mtype[11:4];
        4: b = {mtype[3:0], 4'($urandom_range(15))};
        default: begin
          if ($urandom_range(99) < d3_pct) b = PREAMBLE;
          else b = 8'($urandom_range(255));
        end
      endcase
      push_byte(b);
    end
  endtask

  // mostly good frames with small payloads, some line noise and cut-off frames
  task automatic add_random(input int n);
    int stop;
    int pick;
    int len;
    int k;
    stop = bytes_planned + n;
    while (bytes_planned < stop) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        k = $urandom_range(99);
        if (k < 40) len = $urandom_range(3);
        else if (k < 90) len = $urandom_range(24, 4);
        else len = $urandom_range(80, 25);
        add_frame(10'(len), 12'($urandom_range(4095)), 3);
      end else if (pick < 90) begin
        k = $urandom_range(6, 1);
        for (int i = 0; i < k; i++) push_byte(8'($urandom_range(255)));
      end else begin
        // preamble followed by a header cut off after one to four bytes
        push_byte(PREAMBLE);
        k = $urandom_range(4, 1);
        for (int i = 0; i < k; i++) push_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // wait until every planned byte went in and every result came back
  task automatic drain;
    while (bytes_accepted != bytes_planned || owed_results.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // sender: holds a beat until accepted, otherwise maybe idles
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (tx_bytes.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= tx_bytes.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random back-pressure plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // monitor: predict on every input beat, compare on every output beat
  always @(posedge clk) begin : mon
    res_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        owed_results.push_back(deframe_byte(in_tdata));
        bytes_accepted++;
      end
      if (out_tvalid && out_tready) begin
        if (owed_results.size() == 0) begin
          $error("result beat with no result owed");
          errors++;
        end else begin
          want = owed_results.pop_front();
          check_field("in_frame", want.in_frame, out_tuser);
          check_field("byte_index", want.byte_index, out_tdata[10:0]);
          check_field("frame_done", want.frame_done, out_tlast);
          check_field("frame_bytes", want.frame_bytes, out_tdata[21:11]);
          check_field("message_type", want.message_type, out_tdata[33:22]);
          results_checked++;
          if (want.frame_done) frames_closed++;
        end
      end
    end
  end

  // watchdog: no beat on either side for too long means the block hung
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WDOG_LIMIT) begin
      $display("timeout: no beat for %0d cycles", WDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int mark;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // first phase: slow-ish sender, heavily stalled receiver
    snd_idle_pct = 23;
    rcv_idle_pct = 64;
    // line noise while hunting
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h2C);
    // shortest frame, type taken from the parity bytes, all-ones type
    add_frame(10'd0, 12'hFFF, 0);
    // preamble value inside a frame must not restart it, type zero
    add_frame(10'd1, 12'h000, 100);
    add_frame(10'd3, 12'h5A6, 0);
    drain();
    add_random(40);
    drain();

    // second phase: roles swapped, plus one frame with a length above 255
    snd_idle_pct = 64;
    rcv_idle_pct = 23;
    add_random(40);
    add_frame(10'h100, 12'($urandom_range(4095)), 3);
    drain();

    // third phase: full rate, with one long receiver hold-off mid-stream
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    mark = bytes_accepted;
    add_random(40);
    while (bytes_accepted < mark + 10) @(negedge clk);
    hold_req++;
    drain();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (owed_results.size() != 0) begin
      $error("%0d results never arrived", owed_results.size());
      errors++;
    end
    $display("sent %0d bytes, checked %0d results, %0d frames closed", bytes_accepted,
             results_checked, frames_closed);
    $display("frames from 6 to 262 bytes, noise, cut-off headers, stalls on both sides");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/rtcm3fs_pkg.sv
sv/rtcm3_frame_sync.sv
bench/tb_top.sv
